>>> rtl/bsfd_pkg.sv
// Package for the byte stuffed frame deframer.
// Holds the shared register indexes, result codes and record types.
// No dependencies.
package bsfd_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned IdW    = 16;
	localparam int unsigned KindW  = 2;
	localparam int unsigned CfgIdxW = 2;

	localparam logic [CfgIdxW-1:0] CFG_START  = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_ESCAPE = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_END    = 2'd2;

	localparam logic [ByteW-1:0] START_RESET  = 8'h7E;
	localparam logic [ByteW-1:0] ESCAPE_RESET = 8'h7D;
	localparam logic [ByteW-1:0] END_RESET    = 8'h7F;

	localparam logic [ByteW-1:0] ESCAPE_XOR   = 8'h20;
	localparam logic [ByteW-1:0] LENGTH_BIAS  = 8'd2;
	localparam logic [IdW-1:0]   ID_RESET     = 16'hFFFF;

	localparam logic [KindW-1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [KindW-1:0] KIND_DONE    = 2'd1;
	localparam logic [KindW-1:0] KIND_ABANDON = 2'd2;

	typedef struct packed {
		logic [ByteW-1:0] start_char;
		logic [ByteW-1:0] escape_char;
		logic [ByteW-1:0] end_char;
	} cfg_t;

	typedef struct packed {
		logic [KindW-1:0] kind;
		logic [ByteW-1:0] data_byte;
		logic [ByteW-1:0] byte_index;
		logic [IdW-1:0]   frame_id;
		logic [ByteW-1:0] payload_length;
	} result_t;

endpackage

>>> rtl/bsfd_cfg.sv
// Configuration registers of the deframer: start, escape and end byte values.
// Depends on bsfd_pkg.
module bsfd_cfg import bsfd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [ByteW-1:0]   cfg_data,
	output cfg_t               cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_char  <= START_RESET;
			cfg_q.escape_char <= ESCAPE_RESET;
			cfg_q.end_char    <= END_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START:  cfg_q.start_char  <= cfg_data;
				CFG_ESCAPE: cfg_q.escape_char <= cfg_data;
				CFG_END:    cfg_q.end_char    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/bsfd_core.sv
// Framing state of the deframer and the next-state logic for one received byte.
// Produces at most one result per accepted byte. Depends on bsfd_pkg.
module bsfd_core import bsfd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             accept,
	input  logic [ByteW-1:0] rx_byte,
	output logic             res_valid,
	output result_t          res
);

	localparam logic [2:0] PH_SOF     = 3'd0;
	localparam logic [2:0] PH_LENGTH  = 3'd1;
	localparam logic [2:0] PH_MAJOR   = 3'd2;
	localparam logic [2:0] PH_MINOR   = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;
	localparam logic [2:0] PH_END     = 3'd5;

	logic [2:0]       phase_q, phase_d;
	logic             pending_q, pending_d;
	logic [ByteW-1:0] exp_len_q, exp_len_d;
	logic [ByteW-1:0] count_q, count_d;
	logic [IdW-1:0]   ident_q, ident_d;

	always_comb begin
		logic [ByteW-1:0] b;
		logic [ByteW-1:0] count_inc;
		logic [2:0]       ph;
		phase_d   = phase_q;
		pending_d = pending_q;
		exp_len_d = exp_len_q;
		count_d   = count_q;
		ident_d   = ident_q;
		res_valid = 1'b0;
		res       = '0;
		b         = rx_byte;
		ph        = phase_q;
		count_inc = count_q + 8'd1;
		if (accept) begin
			if (rx_byte == cfg.escape_char) begin
				pending_d = 1'b1;
			end else begin
				pending_d = pending_q;
				if (rx_byte == cfg.start_char) begin
					if (phase_q != PH_SOF) begin
						res_valid = 1'b1;
						res.kind  = KIND_ABANDON;
					end
					ph        = PH_SOF;
					pending_d = 1'b0;
				end
				if (pending_d) begin
					b = rx_byte ^ ESCAPE_XOR;
				end
				pending_d = 1'b0;
				phase_d   = ph;
				case (ph)
					PH_LENGTH: begin
						exp_len_d = b - LENGTH_BIAS;
						phase_d   = PH_MAJOR;
					end
					PH_MAJOR: begin
						ident_d = {b, 8'h00};
						phase_d = PH_MINOR;
					end
					PH_MINOR: begin
						ident_d = {ident_q[IdW-1:ByteW], b};
						phase_d = (exp_len_q == 8'd0) ? PH_END : PH_PAYLOAD;
					end
					PH_PAYLOAD: begin
						res_valid      = 1'b1;
						res.kind       = KIND_PAYLOAD;
						res.data_byte  = b;
						res.byte_index = count_q;
						count_d        = count_inc;
						if (count_inc == exp_len_q) begin
							phase_d = PH_END;
						end
					end
					PH_END: begin
						if (b == cfg.end_char) begin
							res_valid          = 1'b1;
							res.kind           = KIND_DONE;
							res.frame_id       = ident_q;
							res.payload_length = exp_len_q;
							phase_d            = PH_SOF;
						end
					end
					default: begin
						phase_d = PH_SOF;
						if (b == cfg.start_char) begin
							exp_len_d = 8'd0;
							count_d   = 8'd0;
							phase_d   = PH_LENGTH;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SOF;
			pending_q <= 1'b0;
			exp_len_q <= 8'd0;
			count_q   <= 8'd0;
			ident_q   <= ID_RESET;
		end else begin
			phase_q   <= phase_d;
			pending_q <= pending_d;
			exp_len_q <= exp_len_d;
			count_q   <= count_d;
			ident_q   <= ident_d;
		end
	end

	// A raw start byte that is not the escape byte always opens a new frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && rx_byte == cfg.start_char && rx_byte != cfg.escape_char
		|=> phase_q == PH_LENGTH)
		else $error("start byte did not open a frame");

	// An escape byte is dropped and leaves the escape flag set.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && rx_byte == cfg.escape_char |-> !res_valid ##1 pending_q)
		else $error("escape byte not held as pending");

	// Payload results come only from the payload phase.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == KIND_PAYLOAD |-> phase_q == PH_PAYLOAD)
		else $error("payload result outside the payload phase");

	// An abandon result always returns framing to a freshly opened frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == KIND_ABANDON |=> phase_q == PH_LENGTH && count_q == 8'd0)
		else $error("abandon did not restart framing");

endmodule

>>> rtl/bsfd_outbuf.sv
// Output register with one skid entry, so the input side never waits on a
// stall of the current cycle. Depends on bsfd_pkg.
module bsfd_outbuf import bsfd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_res,
	output logic    full,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_res
);

	logic    main_valid_q, skid_valid_q;
	result_t main_q, skid_q;
	logic    pop;

	assign pop = main_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop || !main_valid_q) begin
			main_valid_q <= skid_valid_q || push;
			skid_valid_q <= skid_valid_q && push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !main_valid_q) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
				skid_q <= push_res;
			end else begin
				main_q <= push_res;
			end
		end else if (push) begin
			skid_q <= push_res;
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_res   = main_q;

	// The skid entry is only ever filled behind a waiting main entry.
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid entry holds a request ahead of the output");

	// A request pushed while the output is stalled lands in the skid entry.
	assert property (@(posedge clk) disable iff (!arst_n)
		push && main_valid_q && out_stall |=> skid_valid_q)
		else $error("request lost behind a stalled output");

	// A push is never taken while both entries are occupied.
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !skid_valid_q)
		else $error("push into a full output buffer");

endmodule

>>> rtl/byte_stuffed_frame_deframer.sv
// Top level of the byte stuffed, length framed deframer.
// Instantiates bsfd_cfg, bsfd_core and bsfd_outbuf; depends on bsfd_pkg.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------------------------
//   input    | in_valid / in_stall  | rx_byte
//   output   | out_valid / out_stall| kind, data_byte, byte_index, frame_id,
//            |                      | payload_length
//   config   | cfg_we               | cfg_index, cfg_data
//
// A byte is taken every cycle while in_stall is low; a result is registered in
// the main entry, or in the skid entry behind a stalled output. in_stall rises
// only when both entries hold a request: a register, not the output's stall.
// Reset restores the default start, escape and end bytes and waits for a start.
module byte_stuffed_frame_deframer import bsfd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [ByteW-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [ByteW-1:0]   rx_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [KindW-1:0]   kind,
	output logic [ByteW-1:0]   data_byte,
	output logic [ByteW-1:0]   byte_index,
	output logic [IdW-1:0]     frame_id,
	output logic [ByteW-1:0]   payload_length
);

	cfg_t    cfg;
	logic    accept;
	logic    res_valid;
	result_t res;
	result_t out_res;
	logic    full;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	bsfd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bsfd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.accept    (accept),
		.rx_byte   (rx_byte),
		.res_valid (res_valid),
		.res       (res)
	);

	bsfd_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_res  (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign kind           = out_res.kind;
	assign data_byte      = out_res.data_byte;
	assign byte_index     = out_res.byte_index;
	assign frame_id       = out_res.frame_id;
	assign payload_length = out_res.payload_length;

endmodule
